### rtl/kscd_pkg.sv
// ----------------------------------------------------------------------------
// kscd_pkg
// Shared types, constants and the extended-code remap table for the set-1
// scan code decoder.
// ----------------------------------------------------------------------------
package kscd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 7;
    localparam int unsigned ModW  = 9;

    // special bytes and codes
    localparam logic [ByteW-1:0] PrefixByte = 8'hE0;
    localparam logic [CodeW-1:0] CapsCode   = 7'h3A;

    // key codes, plain or after the extended remap, that drive the held flags
    localparam logic [CodeW-1:0] CodeLShift = 7'h2A;
    localparam logic [CodeW-1:0] CodeRShift = 7'h36;
    localparam logic [CodeW-1:0] CodeLAlt   = 7'h38;
    localparam logic [CodeW-1:0] CodeLCtrl  = 7'h1D;
    localparam logic [CodeW-1:0] CodeRAlt   = 7'h54;
    localparam logic [CodeW-1:0] CodeRCtrl  = 7'h55;
    localparam logic [CodeW-1:0] CodeSysrq  = 7'h56;
    localparam logic [CodeW-1:0] CodeSuper  = 7'h57;

    // bit positions in the held modifier word
    localparam int unsigned ModLShift = 0;
    localparam int unsigned ModRShift = 1;
    localparam int unsigned ModLAlt   = 2;
    localparam int unsigned ModRAlt   = 3;
    localparam int unsigned ModMeta   = 4;
    localparam int unsigned ModLCtrl  = 5;
    localparam int unsigned ModRCtrl  = 6;
    localparam int unsigned ModSysrq  = 7;
    localparam int unsigned ModSuper  = 8;

    typedef struct packed {
        logic             hit;
        logic [CodeW-1:0] code;
    } remap_t;

    // decoder result for one scan byte
    typedef struct packed {
        logic             emit;
        logic [CodeW-1:0] key_code;
        logic             is_press;
        logic             ext_next;
        logic [ModW-1:0]  mods_next;
        logic             caps_next;
    } decode_t;

    // extended code remap, hit is low for dropped codes
    function automatic remap_t remap_extended(input logic [CodeW-1:0] code);
        remap_t r;
        r.hit = 1'b1;
        unique case (code)
            7'h38:        r.code = 7'h54;
            7'h1D:        r.code = 7'h55;
            7'h2A:        r.code = 7'h56;
            7'h5B, 7'h5C: r.code = 7'h57;
            7'h48:        r.code = 7'h5A;
            7'h4D:        r.code = 7'h5B;
            7'h4B:        r.code = 7'h5C;
            7'h50:        r.code = 7'h5D;
            default:
            begin
                r.hit  = 1'b0;
                r.code = code;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/kscd_if.sv
// ----------------------------------------------------------------------------
// kscd_if
// Valid/ready channels for scan bytes in and key events out.
// ----------------------------------------------------------------------------
interface kscd_in_if;
    logic                       valid;
    logic                       ready;
    logic [kscd_pkg::ByteW-1:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface kscd_out_if;
    logic                       valid;
    logic                       ready;
    logic [kscd_pkg::CodeW-1:0] key_code;
    logic                       is_press;
    logic                       left_shift;
    logic                       right_shift;
    logic                       left_alt;
    logic                       right_alt;
    logic                       meta_key;
    logic                       left_control;
    logic                       right_control;
    logic                       sysrq_key;
    logic                       super_key;
    logic                       caps_lock;

    modport source (
        output valid, output key_code, output is_press,
        output left_shift, output right_shift, output left_alt, output right_alt,
        output meta_key, output left_control, output right_control,
        output sysrq_key, output super_key, output caps_lock,
        input  ready
    );
    modport sink (
        input  valid, input key_code, input is_press,
        input  left_shift, input right_shift, input left_alt, input right_alt,
        input  meta_key, input left_control, input right_control,
        input  sysrq_key, input super_key, input caps_lock,
        output ready
    );
endinterface

### rtl/kscd_decode.sv
// ----------------------------------------------------------------------------
// kscd_decode
// Combinational decode of one scan byte against the current prefix, modifier
// and caps state: remap, release bit, flag and caps updates.
// ----------------------------------------------------------------------------
module kscd_decode (
    input  logic [kscd_pkg::ByteW-1:0] scan_byte,
    input  logic                       ext_pending,
    input  logic [kscd_pkg::ModW-1:0]  mods,
    input  logic                       caps,
    output kscd_pkg::decode_t          dec
);
    import kscd_pkg::*;

    logic             is_prefix;
    logic             pressed;
    logic [CodeW-1:0] raw_code;
    remap_t           remap;
    logic [CodeW-1:0] code;
    logic             dropped;
    logic [ModW-1:0]  mods_upd;

    // byte split and extended remap
    always_comb
    begin
        is_prefix = (scan_byte == PrefixByte);
        pressed   = ~scan_byte[ByteW-1];
        raw_code  = scan_byte[CodeW-1:0];
        remap     = remap_extended(raw_code);
        code      = ext_pending ? remap.code : raw_code;
        dropped   = ext_pending & ~remap.hit;
    end

    // held flag update for modifier codes
    always_comb
    begin
        mods_upd = mods;
        unique case (code)
            CodeLShift: mods_upd[ModLShift] = pressed;
            CodeRShift: mods_upd[ModRShift] = pressed;
            CodeLAlt:   mods_upd[ModLAlt]   = pressed;
            CodeRAlt:
            begin
                mods_upd[ModRAlt] = pressed;
                mods_upd[ModMeta] = pressed;
            end
            CodeLCtrl:  mods_upd[ModLCtrl]  = pressed;
            CodeRCtrl:  mods_upd[ModRCtrl]  = pressed;
            CodeSysrq:  mods_upd[ModSysrq]  = pressed;
            CodeSuper:  mods_upd[ModSuper]  = pressed;
            default:    mods_upd = mods;
        endcase
    end

    // result and next state
    always_comb
    begin
        dec.emit     = ~is_prefix & ~dropped;
        dec.key_code = code;
        dec.is_press = pressed;
        dec.ext_next = is_prefix;
        dec.mods_next = dec.emit ? mods_upd : mods;
        dec.caps_next = (dec.emit && pressed && code == CapsCode) ? ~caps : caps;
    end

endmodule

### rtl/keyboard_scancode_decoder_top.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_top
// Set-1 keyboard scan byte decoder: extended prefix handling, key remap,
// held modifier flags and caps lock toggle.
// ----------------------------------------------------------------------------
//  channel    dir   beat contents
//  scan_in    in    scan_byte, one raw scan byte
//  event_out  out   key_code, is_press, nine held flags, caps_lock
//
//  A byte is taken into the input register, decoded combinationally against the
//  held state and written to the result register, one byte per cycle while the
//  result register is not stalled. Prefix and dropped bytes yield no beat.
//  scan_in stays ready while the result register is stalled until a byte with a
//  result waits on it. rst_n clears prefix, flags and caps state.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder_top (
    input  logic     clk,
    input  logic     rst_n,
    kscd_in_if.sink  scan_in,
    kscd_out_if.source event_out
);
    import kscd_pkg::*;

    // input register
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;

    // decoder state
    logic             ext_reg;
    logic [ModW-1:0]  mods_reg;
    logic             caps_reg;

    // result register
    logic             out_valid_reg;
    logic [CodeW-1:0] out_code_reg;
    logic             out_press_reg;
    logic [ModW-1:0]  out_mods_reg;
    logic             out_caps_reg;

    decode_t dec;
    logic    stage_fire;
    logic    in_fire;

    kscd_decode u_decode (
        .scan_byte   (in_byte_reg),
        .ext_pending (ext_reg),
        .mods        (mods_reg),
        .caps        (caps_reg),
        .dec         (dec)
    );

    // handshake
    assign stage_fire    = in_valid_reg & (~dec.emit | ~out_valid_reg | event_out.ready);
    assign scan_in.ready = ~in_valid_reg | stage_fire;
    assign in_fire       = scan_in.valid & scan_in.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (scan_in.ready)
        begin
            in_valid_reg <= scan_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= scan_in.scan_byte;
        end
    end

    // decoder state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg  <= 1'b0;
            mods_reg <= '0;
            caps_reg <= 1'b0;
        end
        else if (stage_fire)
        begin
            ext_reg  <= dec.ext_next;
            mods_reg <= dec.mods_next;
            caps_reg <= dec.caps_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && dec.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (event_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && dec.emit)
        begin
            out_code_reg  <= dec.key_code;
            out_press_reg <= dec.is_press;
            out_mods_reg  <= dec.mods_next;
            out_caps_reg  <= dec.caps_next;
        end
    end

    // output beat
    assign event_out.valid         = out_valid_reg;
    assign event_out.key_code      = out_code_reg;
    assign event_out.is_press      = out_press_reg;
    assign event_out.left_shift    = out_mods_reg[ModLShift];
    assign event_out.right_shift   = out_mods_reg[ModRShift];
    assign event_out.left_alt      = out_mods_reg[ModLAlt];
    assign event_out.right_alt     = out_mods_reg[ModRAlt];
    assign event_out.meta_key      = out_mods_reg[ModMeta];
    assign event_out.left_control  = out_mods_reg[ModLCtrl];
    assign event_out.right_control = out_mods_reg[ModRCtrl];
    assign event_out.sysrq_key     = out_mods_reg[ModSysrq];
    assign event_out.super_key     = out_mods_reg[ModSuper];
    assign event_out.caps_lock     = out_caps_reg;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-1 scan code decoder. Scan bytes go in on
// scan_in with random gaps, key events come back on event_out with random
// stalls. A tracker object keeps its own prefix, held flags and caps state,
// predicts the event, if any, for every accepted byte and checks each event beat
// against the oldest prediction. A long hold-off on the event side backs the
// decoder up so that its input stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kscd_pkg::*;

    // extended codes that have no name in the package
    localparam logic [CodeW-1:0] ExtLWin   = 7'h5B;
    localparam logic [CodeW-1:0] ExtRWin   = 7'h5C;
    localparam logic [CodeW-1:0] ExtUp     = 7'h48;
    localparam logic [CodeW-1:0] ExtRight  = 7'h4D;
    localparam logic [CodeW-1:0] ExtLeft   = 7'h4B;
    localparam logic [CodeW-1:0] ExtDown   = 7'h50;
    localparam logic [CodeW-1:0] ExtPrtSc  = 7'h37;
    localparam logic [CodeW-1:0] ExtUnused = 7'h01;

    // normalized arrow codes
    localparam logic [CodeW-1:0] KeyUp    = 7'h5A;
    localparam logic [CodeW-1:0] KeyRight = 7'h5B;
    localparam logic [CodeW-1:0] KeyLeft  = 7'h5C;
    localparam logic [CodeW-1:0] KeyDown  = 7'h5D;

    localparam int unsigned RandomBytes = 1600;
    localparam int unsigned HoldOffBeat = 300;
    localparam int unsigned HoldOffLen  = 400;
    localparam int unsigned DrainCycles = 32;

    typedef struct packed {
        logic [CodeW-1:0] key_code;
        logic             is_press;
        logic [ModW-1:0]  mods;
        logic             caps;
    } key_event_t;

    // tracks keyboard state and the key events still owed by the decoder
    class keystroke_tracker;
        bit              prefix_armed;
        logic [ModW-1:0] held;
        bit              caps_on;
        key_event_t      due_q[$];
        int unsigned     fails;
        int unsigned     bytes_seen;
        int unsigned     dropped;
        int unsigned     presses;
        int unsigned     releases;
        string           flag_names[ModW] = '{"left_shift", "right_shift", "left_alt",
                                              "right_alt", "meta_key", "left_control",
                                              "right_control", "sysrq_key", "super_key"};

        function new();
            prefix_armed = 1'b0;
            held         = '0;
            caps_on      = 1'b0;
            fails        = 0;
            bytes_seen   = 0;
            dropped      = 0;
            presses      = 0;
            releases     = 0;
        endfunction

        // predict the event caused by one accepted scan byte
        function void note_byte(logic [ByteW-1:0] b);
            key_event_t       ev;
            logic [CodeW-1:0] code;
            logic             down;
            bytes_seen++;
            if (b == PrefixByte)
            begin
                prefix_armed = 1'b1;
                return;
            end
            down = ~b[ByteW-1];
            code = b[CodeW-1:0];

            // extended remap, unknown codes are swallowed
            if (prefix_armed)
            begin
                prefix_armed = 1'b0;
                case (code)
                    CodeLAlt:          code = CodeRAlt;
                    CodeLCtrl:         code = CodeRCtrl;
                    CodeLShift:        code = CodeSysrq;
                    ExtLWin, ExtRWin:  code = CodeSuper;
                    ExtUp:             code = KeyUp;
                    ExtRight:          code = KeyRight;
                    ExtLeft:           code = KeyLeft;
                    ExtDown:           code = KeyDown;
                    default:
                    begin
                        dropped++;
                        return;
                    end
                endcase
            end

            // held flags
            case (code)
                CodeLShift: held[ModLShift] = down;
                CodeRShift: held[ModRShift] = down;
                CodeLAlt:   held[ModLAlt]   = down;
                CodeRAlt:
                begin
                    held[ModRAlt] = down;
                    held[ModMeta] = down;
                end
                CodeLCtrl:  held[ModLCtrl]  = down;
                CodeRCtrl:  held[ModRCtrl]  = down;
                CodeSysrq:  held[ModSysrq]  = down;
                CodeSuper:  held[ModSuper]  = down;
                default: ;
            endcase

            if (down && code == CapsCode)
                caps_on = ~caps_on;

            ev.key_code = code;
            ev.is_press = down;
            ev.mods     = held;
            ev.caps     = caps_on;
            due_q.push_back(ev);
        endfunction

        // compare one event beat with the oldest prediction
        function void check_event(key_event_t got);
            key_event_t want;
            if (due_q.size() == 0)
            begin
                $error("unexpected key event: key_code %h is_press %0b",
                       got.key_code, got.is_press);
                fails++;
                return;
            end
            want = due_q.pop_front();
            if (got.key_code !== want.key_code)
            begin
                $error("key_code: expected %h, got %h", want.key_code, got.key_code);
                fails++;
            end
            if (got.is_press !== want.is_press)
            begin
                $error("is_press: expected %0b, got %0b", want.is_press, got.is_press);
                fails++;
            end
            for (int i = 0; i < ModW; i++)
            begin
                if (got.mods[i] !== want.mods[i])
                begin
                    $error("%s: expected %0b, got %0b", flag_names[i], want.mods[i],
                           got.mods[i]);
                    fails++;
                end
            end
            if (got.caps !== want.caps)
            begin
                $error("caps_lock: expected %0b, got %0b", want.caps, got.caps);
                fails++;
            end
            if (want.is_press)
                presses++;
            else
                releases++;
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    kscd_in_if  scan_in ();
    kscd_out_if event_out ();

    keyboard_scancode_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_in   (scan_in),
        .event_out (event_out)
    );

    keystroke_tracker board = new();

    bit               send_steady;
    int unsigned      input_stalls;
    logic [CodeW-1:0] ext_keys [9];
    logic [CodeW-1:0] mod_keys [8];

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ByteW-1:0] press_byte(logic [CodeW-1:0] code);
        return {1'b0, code};
    endfunction

    function automatic logic [ByteW-1:0] release_byte(logic [CodeW-1:0] code);
        return {1'b1, code};
    endfunction

    // offer one scan byte after a random gap, hold it until accepted
    task automatic send_scan(input logic [ByteW-1:0] b);
        int unsigned gap;
        gap = send_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            scan_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_in.valid     <= 1'b1;
        scan_in.scan_byte <= b;
        @(posedge clk);
        while (!scan_in.ready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        board.note_byte(b);
    endtask

    // event sink: random stalls, one long hold-off, check every beat
    initial
    begin : event_sink
        int unsigned hold;
        int unsigned beats;
        bit          steady;
        key_event_t  got;
        event_out.ready = 1'b0;
        beats  = 0;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats == HoldOffBeat)
                hold = HoldOffLen;
            else
                hold = steady ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                event_out.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            event_out.ready <= 1'b1;
            @(posedge clk);
            while (!event_out.valid)
                @(posedge clk);
            got.key_code        = event_out.key_code;
            got.is_press        = event_out.is_press;
            got.mods[ModLShift] = event_out.left_shift;
            got.mods[ModRShift] = event_out.right_shift;
            got.mods[ModLAlt]   = event_out.left_alt;
            got.mods[ModRAlt]   = event_out.right_alt;
            got.mods[ModMeta]   = event_out.meta_key;
            got.mods[ModLCtrl]  = event_out.left_control;
            got.mods[ModRCtrl]  = event_out.right_control;
            got.mods[ModSysrq]  = event_out.sysrq_key;
            got.mods[ModSuper]  = event_out.super_key;
            got.caps            = event_out.caps_lock;
            board.check_event(got);
            beats++;
            if (beats % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
        end
    end

    // main stimulus
    initial
    begin : scan_source
        logic [ByteW-1:0] opening [];
        logic             brk;
        int unsigned      n;
        // known values on every input from time zero
        rst_n             = 1'b0;
        scan_in.valid     = 1'b0;
        scan_in.scan_byte = '0;
        send_steady  = 1'b0;
        input_stalls = 0;
        ext_keys = '{CodeLAlt, CodeLCtrl, CodeLShift, ExtLWin, ExtRWin,
                     ExtUp, ExtRight, ExtLeft, ExtDown};
        mod_keys = '{CodeLShift, CodeRShift, CodeLAlt, CodeLCtrl,
                     CodeRAlt, CodeRCtrl, CodeSysrq, CodeSuper};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, repeated prefix, dropped codes, caps,
        // plain codes that alias extended keys
        opening = '{8'h00, 8'h7F, release_byte(7'h00), 8'hFF,
                    PrefixByte, PrefixByte, press_byte(CodeLAlt),
                    PrefixByte, release_byte(CodeLAlt),
                    PrefixByte, press_byte(ExtPrtSc),
                    PrefixByte, press_byte(ExtUnused),
                    press_byte(CapsCode), release_byte(CapsCode),
                    press_byte(CodeLShift), press_byte(CodeRAlt),
                    release_byte(CodeRAlt), release_byte(CodeLShift),
                    PrefixByte, press_byte(ExtLWin),
                    PrefixByte, release_byte(ExtDown)};
        foreach (opening[i])
            send_scan(opening[i]);

        // random: mostly real key traffic, some raw noise
        n = 0;
        while (n < RandomBytes)
        begin
            if (n % 50 == 0)
                send_steady = ($urandom_range(0, 3) == 0);
            brk = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    send_scan({brk, mod_keys[$urandom_range(0, 7)]});
                    n += 1;
                end
                3, 4, 5:
                begin
                    send_scan(PrefixByte);
                    send_scan({brk, ext_keys[$urandom_range(0, 8)]});
                    n += 2;
                end
                6:
                begin
                    send_scan({brk, CapsCode});
                    n += 1;
                end
                7, 8:
                begin
                    send_scan(8'($urandom_range(0, 255)));
                    n += 1;
                end
                default:
                begin
                    send_scan(PrefixByte);
                    send_scan(8'($urandom_range(0, 255)));
                    n += 2;
                end
            endcase
        end
        scan_in.valid <= 1'b0;

        // drain and make sure nothing extra shows up
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("run covered %0d scan bytes: %0d presses, %0d releases, %0d extended drops",
                 board.bytes_seen, board.presses, board.releases, board.dropped);
        $display("scan input stalled %0d cycles under event back-pressure", input_stalls);
        if (board.fails == 0)
            $display("[keyboard_scancode_decoder_top] OK");
        else
            $display("[keyboard_scancode_decoder_top] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("[keyboard_scancode_decoder_top] ERROR");
        $finish;
    end

endmodule
